/* rtl/tdpt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

	// First trial divisor and its square.
	localparam int unsigned FirstDivisor = 2;
	localparam int unsigned FirstSquare  = FirstDivisor * FirstDivisor;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // latch the number, set the divisor to the first divisor and the square to its square
		logic div_start;  // clear the remainder and arm the bit counter
		logic div_step;   // one restoring remainder step
		logic advance;    // move to the next divisor and its square
		logic res_load;   // load the result register
		logic res_val;    // value loaded into the result register
	} tdpt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic small_n;    // number is below two
		logic past_bound; // square of the current divisor exceeds the number
		logic next_past;  // square of the next divisor exceeds the number
		logic div_last;   // the remainder step under way is the last one
		logic rem_zero;   // remainder of the finished division is zero
	} tdpt_sts_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_BOUND = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_NEXT  = 5'b01000,
		ST_FIN   = 5'b10000
	} tdpt_state_t;

endpackage

`default_nettype wire

/* rtl/tdpt_num_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface tdpt_num_if #(
	parameter int NUMBER_BITS = 31
);
	logic                   valid;
	logic                   ready;
	logic [NUMBER_BITS-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink   (input valid, input number, output ready);
endinterface

`default_nettype wire

/* rtl/tdpt_res_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface tdpt_res_if;
	logic valid;
	logic ready;
	logic is_prime;

	modport source (output valid, output is_prime, input ready);
	modport sink   (input valid, input is_prime, output ready);
endinterface

`default_nettype wire

/* rtl/tdpt_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module tdpt_datapath
	import tdpt_pkg::*;
#(
	parameter int NUMBER_BITS = 31
) (
	input  wire                    clk,
	input  wire  [NUMBER_BITS-1:0] number,
	input  tdpt_cmd_t              cmd,
	output tdpt_sts_t              sts,
	output logic                   is_prime
);

	localparam int W   = NUMBER_BITS;
	localparam int DW  = (W + 1) / 2 + 1;  // divisor never exceeds floor(sqrt(n)) + 1
	localparam int SQW = W + 1;            // square of that divisor
	localparam int CW  = $clog2(W);

	logic [W-1:0]   n_q;
	logic [W-1:0]   sh_q;
	logic [DW-1:0]  d_q;
	logic [SQW-1:0] sq_q;
	logic [DW-1:0]  r_q;
	logic [CW-1:0]  cnt_q;
	logic           res_q;

	logic [DW:0]    trial;
	logic [DW:0]    trial_sub;
	logic           trial_ge;
	logic [SQW-1:0] sq_next;

	// Restoring remainder step: bring down the next bit of the number.
	assign trial     = {r_q, sh_q[W-1]};
	assign trial_ge  = trial >= {1'b0, d_q};
	assign trial_sub = trial - {1'b0, d_q};

	// (d + 1)^2 = d^2 + 2d + 1
	assign sq_next = sq_q + SQW'({d_q, 1'b1});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q  <= number;
			d_q  <= DW'(FirstDivisor);
			sq_q <= SQW'(FirstSquare);
		end
		if (cmd.advance) begin
			d_q  <= d_q + DW'(1);
			sq_q <= sq_next;
		end
		if (cmd.div_start) begin
			r_q   <= '0;
			sh_q  <= n_q;
			cnt_q <= CW'(W - 1);
		end else if (cmd.div_step) begin
			r_q   <= trial_ge ? trial_sub[DW-1:0] : trial[DW-1:0];
			sh_q  <= {sh_q[W-2:0], 1'b0};
			cnt_q <= cnt_q - CW'(1);
		end
		if (cmd.res_load) begin
			res_q <= cmd.res_val;
		end
	end

	always_comb begin
		sts.small_n    = n_q < W'(FirstDivisor);
		sts.past_bound = sq_q > {1'b0, n_q};
		sts.next_past  = sq_next > {1'b0, n_q};
		sts.div_last   = cnt_q == '0;
		sts.rem_zero   = r_q == '0;
	end

	assign is_prime = res_q;

endmodule

`default_nettype wire

/* rtl/tdpt_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module tdpt_ctrl
	import tdpt_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire       out_ready,
	input  tdpt_sts_t sts,
	output tdpt_cmd_t cmd
);

	tdpt_state_t state_q, state_d;
	logic        verdict_q, verdict_d;
	logic        out_valid_q, out_valid_d;
	logic        res_free;

	assign res_free  = !out_valid_q || out_ready;
	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		verdict_d   = verdict_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_BOUND;
				end
			end
			ST_BOUND: begin
				if (sts.small_n) begin
					verdict_d = 1'b0;
					state_d   = ST_FIN;
				end else if (sts.past_bound) begin
					verdict_d = 1'b1;
					state_d   = ST_FIN;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (sts.rem_zero) begin
					verdict_d = 1'b0;
					state_d   = ST_FIN;
				end else if (sts.next_past) begin
					verdict_d = 1'b1;
					state_d   = ST_FIN;
				end else begin
					cmd.advance   = 1'b1;
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_FIN: begin
				if (res_free) begin
					cmd.res_load = 1'b1;
					cmd.res_val  = verdict_q;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			verdict_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			verdict_q   <= verdict_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/trial_division_primality_test_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel     Role    Payload
// number_ch   sink    number   [NUMBER_BITS-1:0], unsigned integer to test
// result_ch   source  is_prime [0], 1 when the number is prime
//
// Each trial divisor tried costs one bit-serial remainder pass over the NUMBER_BITS
// bits of the number in the shared restoring divider plus one decision state (ST_NEXT).
// Reset (arst_n low) returns the controller to idle and drops a pending result.
// A new item is taken while an earlier result still waits on result_ch; the
// controller holds its verdict only if that result has still not been taken.

module trial_division_primality_test_core
	import tdpt_pkg::*;
#(
	parameter int NUMBER_BITS = 31
) (
	input  wire        clk,
	input  wire        arst_n,
	tdpt_num_if.sink   number_ch,
	tdpt_res_if.source result_ch
);

	tdpt_cmd_t cmd;
	tdpt_sts_t sts;

	// The controller sequences bound check, remainder passes and verdict.
	tdpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (number_ch.valid),
		.in_ready  (number_ch.ready),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the number, the divisor with its running square,
	// the serial divider and the result register.
	tdpt_datapath #(
		.NUMBER_BITS (NUMBER_BITS)
	) u_datapath (
		.clk      (clk),
		.number   (number_ch.number),
		.cmd      (cmd),
		.sts      (sts),
		.is_prime (result_ch.is_prime)
	);

endmodule

`default_nettype wire

/* verif/tb_trial_division_primality_test_core.sv */
`timescale 1ns / 1ps

module tb_trial_division_primality_test_core;
	import tdpt_pkg::*;

	localparam int NUMBER_BITS = 31;
	localparam int unsigned MAX_NUMBER = (32'd1 << NUMBER_BITS) - 1;

	// The slowest number used here is a prime just above 2**20 or a product of two
	// primes just above a thousand. Even if every item were that slow, the run would
	// stay well inside the limit, which is set with a wide margin.
	localparam longint unsigned TIMEOUT_CYCLES = 20_000_000;

	// Cycles to wait after the last verdict, so that a stray extra result still shows up.
	localparam int unsigned SETTLE_CYCLES = 200;

	logic clk;
	logic arst_n;

	tdpt_num_if #(.NUMBER_BITS(NUMBER_BITS)) number_ch();
	tdpt_res_if result_ch();

	trial_division_primality_test_core #(
		.NUMBER_BITS(NUMBER_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.number_ch(number_ch),
		.result_ch(result_ch)
	);

	// Verdicts predicted for accepted numbers, oldest first.
	bit              verdict_q[$];
	int unsigned     error_count;
	longint unsigned cycle_count;

	// When set, neither the sender nor the receiver inserts idle cycles.
	bit no_idle;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Trial division with the exact bound d*d <= n. The bound is written as
	// d <= n / d so that the square never has to be formed.
	function automatic bit prime_verdict(input logic [NUMBER_BITS-1:0] n);
		longint unsigned value;
		longint unsigned divisor;
		value = 64'(n);
		if (value < 2) begin
			return 1'b0;
		end
		if (value == 2) begin
			return 1'b1;
		end
		for (divisor = 2; divisor <= value / divisor; divisor++) begin
			if (value % divisor == 0) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Smallest prime at or above the given start.
	function automatic logic [NUMBER_BITS-1:0] next_prime(input int unsigned start);
		logic [NUMBER_BITS-1:0] value;
		value = NUMBER_BITS'(start);
		while (!prime_verdict(value)) begin
			value++;
		end
		return value;
	endfunction

	// The block runs one full remainder pass for each trial divisor. A uniformly random
	// 31-bit number is prime often enough, and such a prime is tried against every divisor
	// up to its square root, so the numbers are drawn from classes that stay cheap but
	// still cover the behavior. Multiples of a small factor over the whole range make
	// every bit of the field take both values. Primes and products of two primes reach
	// the loop deep enough to test the bound.
	function automatic logic [NUMBER_BITS-1:0] draw_number();
		int unsigned kind;
		int unsigned factor;
		int unsigned cofactor;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2, 3: begin
				return NUMBER_BITS'($urandom_range(0, 65535));
			end
			4, 5, 6: begin
				factor   = $urandom_range(2, 63);
				cofactor = $urandom_range(1, MAX_NUMBER / factor);
				return NUMBER_BITS'(factor * cofactor);
			end
			7: begin
				return next_prime($urandom_range(2, 1000)) * next_prime($urandom_range(2, 1000));
			end
			8: begin
				return next_prime($urandom_range(65536, 1 << 20));
			end
			default: begin
				return NUMBER_BITS'($urandom_range(0, 15));
			end
		endcase
	endfunction

	// Offers one number after a random gap and holds it until the block takes it.
	// Valid is only lowered when a gap follows, so that for back-to-back items it
	// stays high without a second assignment in the same time step.
	task automatic send_number(input logic [NUMBER_BITS-1:0] n);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			number_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		number_ch.valid  <= 1'b1;
		number_ch.number <= n;
		do @(posedge clk); while (!number_ch.ready);
	endtask

	// Stops offering numbers and waits until every predicted verdict has been checked.
	// It waits for a clock edge first, so that the prediction for a number taken at the edge
	// just seen has surely been recorded.
	task automatic wait_for_verdicts();
		number_ch.valid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Zero and one are not prime, two is. Large even numbers, a large multiple of five
	// and 2**30 set the upper bits of the field and are rejected by the first divisors.
	task automatic test_field_extremes();
		send_number(0);
		send_number(1);
		send_number(2);
		send_number(3);
		send_number(4);
		send_number(31'h7FFF_FFFE);
		send_number(31'h7FFF_FFFD);
		send_number(31'h4000_0000);
	endtask

	// Small primes and squares of odd primes, which are odd composites whose factor is not
	// the first divisor tried.
	task automatic test_small_numbers();
		send_number(5);
		send_number(9);
		send_number(25);
		send_number(97);
		send_number(121);
	endtask

	// The square of a prime is only rejected when the divisor reaches its root, which
	// checks that the bound includes equality. The product of two adjacent primes and
	// the prime 1000003 run the loop for about a thousand divisors, and 65521 for about 250.
	task automatic test_divisor_bound();
		send_number(NUMBER_BITS'(1009 * 1009));
		send_number(NUMBER_BITS'(1009 * 1013));
		send_number(1000003);
		send_number(65521);
	endtask

	// A run with no idle cycles on either side, so that numbers arrive while earlier
	// verdicts are still waiting to be taken.
	task automatic test_back_to_back();
		no_idle = 1'b1;
		repeat (20) send_number(draw_number());
		no_idle = 1'b0;
	endtask

	// Random numbers with random gaps. Halfway through, the sender pauses until the
	// block has handed back every verdict, and then starts again from an empty pipeline.
	task automatic test_random_numbers();
		repeat (40) send_number(draw_number());
		wait_for_verdicts();
		repeat (40) send_number(draw_number());
	endtask

	// Receiver: for every result it stalls for a random number of cycles (none when no_idle
	// is set) and then holds ready until the block presents a result.
	initial begin
		int unsigned stall;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 16);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	// Checks each verdict against the oldest prediction and records new predictions.
	// The verdict is checked first: a verdict taken in the same cycle as a number
	// belongs to an earlier number.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (verdict_q.size() == 0) begin
					$error("is_prime: no verdict expected, actual %0d", result_ch.is_prime);
					error_count++;
				end else begin
					if (result_ch.is_prime !== verdict_q[0]) begin
						$error("is_prime: expected %0d, actual %0d", verdict_q[0],
							result_ch.is_prime);
						error_count++;
					end
					void'(verdict_q.pop_front());
				end
			end
			if (number_ch.valid && number_ch.ready) begin
				verdict_q.insert(verdict_q.size(), prime_verdict(number_ch.number));
			end
		end
	end

	// A hung block must not stall the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > TIMEOUT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		cycle_count = 0;
		no_idle     = 1'b0;
		arst_n           <= 1'b0;
		number_ch.valid  <= 1'b0;
		number_ch.number <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_small_numbers();
		test_divisor_bound();
		test_back_to_back();
		test_random_numbers();

		// Every number has been taken; wait for the last verdicts and for anything
		// left over.
		wait_for_verdicts();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* trial_division_primality_test_core.f */
rtl/tdpt_pkg.sv
rtl/tdpt_num_if.sv
rtl/tdpt_res_if.sv
rtl/tdpt_datapath.sv
rtl/tdpt_ctrl.sv
rtl/trial_division_primality_test_core.sv
verif/tb_trial_division_primality_test_core.sv
